// ===== hdl/blm_pkg.sv =====
package blm_pkg;

  // Fixed-point layout of the filters.
  localparam int unsigned VOLT_BITS = 13;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned SV_W      = VOLT_BITS + FRAC_BITS;
  localparam int unsigned SP_W      = PCT_W + FRAC_BITS;

  // Smoothing weights in Q8: new = (old*184 + raw*72 + 128) >> 8.
  localparam int unsigned WEIGHT_SHIFT = 8;
  localparam int unsigned ACC_W        = SV_W + WEIGHT_SHIFT + 1;
  localparam logic [7:0]  W_OLD        = 8'd184;
  localparam logic [7:0]  W_NEW        = 8'd72;
  localparam logic [7:0]  W_ROUND      = 8'd128;

  // Percent limits and the edges at which the shown percent always follows.
  localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;
  localparam logic [PCT_W-1:0] SHOW_LOW_EDGE  = 7'd10;
  localparam logic [PCT_W-1:0] SHOW_HIGH_EDGE = 7'd99;

  // Runtime estimator widths.
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MUL_A_W   = TIME_W;
  localparam int unsigned MUL_B_W   = PCT_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DEN_W     = 23;
  localparam int unsigned DVS_W     = DEN_W + 1;
  localparam int unsigned NUM_W     = PROD_W + 1;
  localparam int unsigned RUN_W     = 24;
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [RUN_W-1:0] RUN_MAX = 24'hFFFFFF;

  // Critical counter.
  localparam int unsigned RUN_CNT_W = 8;
  localparam logic [RUN_CNT_W-1:0] CRIT_RUN_MAX = 8'd255;

  // Sample intervals.
  localparam int unsigned IVL_W = 20;
  localparam logic [IVL_W-1:0] IVL_LOW  = 20'd60000;
  localparam logic [IVL_W-1:0] IVL_PLAY = 20'd600000;
  localparam logic [IVL_W-1:0] IVL_IDLE = 20'd180000;

  // Protection actions.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_WARN = 2'd1;
  localparam logic [1:0] ACT_SHUT = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_WARN_MV      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRITICAL_MV      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_WARN_PCT     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRITICAL_PCT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISPLAY_HYST     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_RUNTIME_MIN_DROP = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_RUNTIME_MIN_MS   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRIT_SAMPLES     = 3'd7;

  // Register reset values.
  localparam logic [VOLT_BITS-1:0] RST_LOW_WARN_MV      = 13'd3500;
  localparam logic [VOLT_BITS-1:0] RST_CRITICAL_MV      = 13'd3300;
  localparam logic [PCT_W-1:0]     RST_LOW_WARN_PCT     = 7'd5;
  localparam logic [PCT_W-1:0]     RST_CRITICAL_PCT     = 7'd1;
  localparam logic [PCT_W-1:0]     RST_DISPLAY_HYST     = 7'd2;
  localparam logic [PCT_W-1:0]     RST_RUNTIME_MIN_DROP = 7'd3;
  localparam logic [TIME_W-1:0]    RST_RUNTIME_MIN_MS   = 32'd600000;
  localparam logic [RUN_CNT_W-1:0] RST_CRIT_SAMPLES     = 8'd2;

  // One battery sample.
  typedef struct packed {
    logic [TIME_W-1:0]    now_ms;
    logic                 battery_present;
    logic [VOLT_BITS-1:0] raw_voltage_mv;
    logic [PCT_W-1:0]     raw_percent;
    logic                 force_display;
    logic                 playing;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [PCT_W-1:0] displayed_percent;
    logic [RUN_W-1:0] runtime_minutes;
    logic             runtime_valid;
    logic [1:0]       protect_action;
    logic [IVL_W-1:0] next_interval_ms;
    logic             seeded;
  } out_item_t;

  // Exponential smoothing step, rounded half up then truncated.
  function automatic logic [SV_W-1:0] smooth_q(input logic [SV_W-1:0] old_q,
                                               input logic [SV_W-1:0] raw_q);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(old_q) * ACC_W'(W_OLD) + ACC_W'(raw_q) * ACC_W'(W_NEW) + ACC_W'(W_ROUND);
    return acc[WEIGHT_SHIFT +: SV_W];
  endfunction

endpackage

// ===== hdl/battery_level_monitor.sv =====
// Battery level monitor. Each accepted sample gives exactly one result. A sample runs through
// a short sequencer: smoothing, then for a present, seeded battery shown-percent hysteresis and
// anchor check, then protection check, each in its own state. When an estimate is due, the product
// shown * elapsed is formed by a 7-step shift-and-add multiplier and then divided by a 40-step
// restoring divider. One sample is worked on at a time; the input is stalled until its result is
// in the output register, and the next sample may be taken while that result still waits.
module battery_level_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  blm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output blm_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [blm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [blm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned VOLT_BITS = blm_pkg::VOLT_BITS;
  localparam int unsigned FRAC_BITS = blm_pkg::FRAC_BITS;
  localparam int unsigned PCT_W     = blm_pkg::PCT_W;
  localparam int unsigned SV_W      = blm_pkg::SV_W;
  localparam int unsigned SP_W      = blm_pkg::SP_W;
  localparam int unsigned TIME_W    = blm_pkg::TIME_W;
  localparam int unsigned DEN_W     = blm_pkg::DEN_W;
  localparam int unsigned DVS_W     = blm_pkg::DVS_W;
  localparam int unsigned NUM_W     = blm_pkg::NUM_W;
  localparam int unsigned PROD_W    = blm_pkg::PROD_W;
  localparam int unsigned RUN_W     = blm_pkg::RUN_W;
  localparam int unsigned RUN_CNT_W = blm_pkg::RUN_CNT_W;
  localparam int unsigned IVL_W     = blm_pkg::IVL_W;
  localparam int unsigned FILT_W    = SP_W + 1 - FRAC_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SMOOTH = 3'd1;
  localparam logic [2:0] S_SHOW   = 3'd2;
  localparam logic [2:0] S_ANCH   = 3'd3;
  localparam logic [2:0] S_PROT   = 3'd4;
  localparam logic [2:0] S_MULW   = 3'd5;
  localparam logic [2:0] S_DIVW   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Configuration registers.
  logic [VOLT_BITS-1:0] low_warn_mv_r;
  logic [VOLT_BITS-1:0] critical_mv_r;
  logic [PCT_W-1:0]     low_warn_pct_r;
  logic [PCT_W-1:0]     critical_pct_r;
  logic [PCT_W-1:0]     display_hyst_r;
  logic [PCT_W-1:0]     runtime_min_drop_r;
  logic [TIME_W-1:0]    runtime_min_ms_r;
  logic [RUN_CNT_W-1:0] crit_samples_r;

  // Monitor state.
  logic                 is_present_r;
  logic                 is_seeded_r;
  logic [SV_W-1:0]      smooth_voltage_r;
  logic [SP_W-1:0]      smooth_percent_r;
  logic [PCT_W-1:0]     shown_percent_r;
  logic [PCT_W-1:0]     anchor_percent_r;
  logic [TIME_W-1:0]    anchor_time_r;
  logic [RUN_W-1:0]     estimate_minutes_r;
  logic                 estimate_ready_r;
  logic [RUN_CNT_W-1:0] critical_run_r;

  // Captured request and per-sample working registers.
  blm_pkg::in_item_t    req_r;
  logic                 est_go_r;
  logic [DEN_W-1:0]     den_r;
  logic [1:0]           act_r;
  logic [IVL_W-1:0]     ivl_r;

  // Output register.
  logic                 out_valid_r;
  blm_pkg::out_item_t   out_r;

  logic                 in_accept;
  logic                 out_free;
  logic [PCT_W-1:0]     pct_capped;
  logic [SV_W-1:0]      sv_smooth;
  logic [SP_W-1:0]      sp_smooth;
  logic [SP_W:0]        sp_round;
  logic [FILT_W-1:0]    filt_wide;
  logic [PCT_W-1:0]     filt;
  logic [PCT_W-1:0]     diff;
  logic                 show_take;
  logic                 anchor_rise;
  logic [PCT_W-1:0]     drop;
  logic [PCT_W-1:0]     need;
  logic [TIME_W-1:0]    elapsed;
  logic                 est_cond;
  logic [DEN_W-1:0]     den_nxt;
  logic                 volt_crit;
  logic                 volt_low;
  logic                 low;
  logic                 crit;
  logic [RUN_CNT_W-1:0] run_nxt;
  logic [1:0]           act_nxt;
  logic [IVL_W-1:0]     ivl_nxt;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_prod;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic [NUM_W-1:0]     div_quo;
  logic [RUN_W-1:0]     est_sat;

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Gauge percent is capped at 100 before any use.
  assign pct_capped = (in_data.raw_percent > blm_pkg::PCT_MAX) ? blm_pkg::PCT_MAX
                                                                : in_data.raw_percent;

  // Smoothing of both filters.
  assign sv_smooth = blm_pkg::smooth_q(smooth_voltage_r,
                                       SV_W'({req_r.raw_voltage_mv, {FRAC_BITS{1'b0}}}));
  assign sp_smooth = SP_W'(blm_pkg::smooth_q(SV_W'(smooth_percent_r),
                                             SV_W'({req_r.raw_percent, {FRAC_BITS{1'b0}}})));

  // Filtered percent, rounded and capped, and the hysteresis decision.
  assign sp_round  = {1'b0, smooth_percent_r} + (SP_W + 1)'(1 << (FRAC_BITS - 1));
  assign filt_wide = sp_round[FRAC_BITS +: FILT_W];
  assign filt      = (filt_wide > FILT_W'(blm_pkg::PCT_MAX)) ? blm_pkg::PCT_MAX
                                                               : filt_wide[PCT_W-1:0];
  assign diff      = (filt >= shown_percent_r) ? (filt - shown_percent_r)
                                               : (shown_percent_r - filt);
  assign show_take = req_r.force_display || (diff >= display_hyst_r) ||
                     (filt <= blm_pkg::SHOW_LOW_EDGE) || (filt >= blm_pkg::SHOW_HIGH_EDGE);

  // Anchor tracking and the condition for a new runtime estimate.
  assign anchor_rise = (shown_percent_r > anchor_percent_r);
  assign drop        = anchor_percent_r - shown_percent_r;
  assign need        = (runtime_min_drop_r == '0) ? PCT_W'(1) : runtime_min_drop_r;
  assign elapsed     = req_r.now_ms - anchor_time_r;
  assign est_cond    = (drop >= need) && (elapsed >= runtime_min_ms_r);
  assign den_nxt     = DEN_W'(drop) * DEN_W'(blm_pkg::MS_PER_MIN);

  // Protection check and interval choice on the updated state.
  assign volt_crit = (smooth_voltage_r <= SV_W'({critical_mv_r, {FRAC_BITS{1'b0}}}));
  assign volt_low  = (smooth_voltage_r <= SV_W'({low_warn_mv_r, {FRAC_BITS{1'b0}}}));
  assign low       = is_present_r && is_seeded_r &&
                     (volt_low || (shown_percent_r <= low_warn_pct_r));
  assign crit      = volt_crit || (shown_percent_r <= critical_pct_r);

  always_comb begin
    run_nxt = '0;
    act_nxt = blm_pkg::ACT_NONE;
    if (is_present_r && is_seeded_r) begin
      if (crit) begin
        run_nxt = (critical_run_r == blm_pkg::CRIT_RUN_MAX) ? critical_run_r
                                                             : critical_run_r + 1'b1;
      end
      if (run_nxt >= crit_samples_r) begin
        act_nxt = blm_pkg::ACT_SHUT;
      end else if (low) begin
        act_nxt = blm_pkg::ACT_WARN;
      end
    end
  end

  assign ivl_nxt = low ? blm_pkg::IVL_LOW
                       : (req_r.playing ? blm_pkg::IVL_PLAY : blm_pkg::IVL_IDLE);

  // Runtime estimate: round_half_up(num / den) = (2*num + den) / (2*den).
  assign mul_start    = (state_r == S_ANCH) && !anchor_rise && est_cond;
  assign div_start    = (state_r == S_MULW) && mul_done;
  assign div_dividend = {mul_prod, 1'b0} + NUM_W'(den_r);
  assign div_divisor  = {den_r, 1'b0};
  assign est_sat      = (div_quo[NUM_W-1:RUN_W] != '0) ? blm_pkg::RUN_MAX
                                                       : div_quo[RUN_W-1:0];

  blm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (elapsed),
    .mplier (shown_percent_r),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  blm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        if (req_r.battery_present && is_seeded_r) state_nxt = S_SHOW;
        else state_nxt = S_PROT;
      end
      S_SHOW: begin
        state_nxt = S_ANCH;
      end
      S_ANCH: begin
        state_nxt = S_PROT;
      end
      S_PROT: begin
        state_nxt = est_go_r ? S_MULW : S_DONE;
      end
      S_MULW: begin
        if (mul_done) state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_warn_mv_r      <= blm_pkg::RST_LOW_WARN_MV;
      critical_mv_r      <= blm_pkg::RST_CRITICAL_MV;
      low_warn_pct_r     <= blm_pkg::RST_LOW_WARN_PCT;
      critical_pct_r     <= blm_pkg::RST_CRITICAL_PCT;
      display_hyst_r     <= blm_pkg::RST_DISPLAY_HYST;
      runtime_min_drop_r <= blm_pkg::RST_RUNTIME_MIN_DROP;
      runtime_min_ms_r   <= blm_pkg::RST_RUNTIME_MIN_MS;
      crit_samples_r     <= blm_pkg::RST_CRIT_SAMPLES;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        blm_pkg::CFG_LOW_WARN_MV:      low_warn_mv_r      <= cfg_wdata[VOLT_BITS-1:0];
        blm_pkg::CFG_CRITICAL_MV:      critical_mv_r      <= cfg_wdata[VOLT_BITS-1:0];
        blm_pkg::CFG_LOW_WARN_PCT:     low_warn_pct_r     <= cfg_wdata[PCT_W-1:0];
        blm_pkg::CFG_CRITICAL_PCT:     critical_pct_r     <= cfg_wdata[PCT_W-1:0];
        blm_pkg::CFG_DISPLAY_HYST:     display_hyst_r     <= cfg_wdata[PCT_W-1:0];
        blm_pkg::CFG_RUNTIME_MIN_DROP: runtime_min_drop_r <= cfg_wdata[PCT_W-1:0];
        blm_pkg::CFG_RUNTIME_MIN_MS:   runtime_min_ms_r   <= cfg_wdata[TIME_W-1:0];
        blm_pkg::CFG_CRIT_SAMPLES:     crit_samples_r     <= cfg_wdata[RUN_CNT_W-1:0];
      endcase
    end
  end

  // Monitor state updates, one phase per sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_present_r       <= 1'b0;
      is_seeded_r        <= 1'b0;
      smooth_voltage_r   <= '0;
      smooth_percent_r   <= '0;
      shown_percent_r    <= '0;
      anchor_percent_r   <= '0;
      anchor_time_r      <= '0;
      estimate_minutes_r <= '0;
      estimate_ready_r   <= 1'b0;
      critical_run_r     <= '0;
      est_go_r           <= 1'b0;
    end else begin
      unique case (state_r)
        S_SMOOTH: begin
          est_go_r <= 1'b0;
          if (!req_r.battery_present) begin
            is_present_r   <= 1'b0;
            critical_run_r <= '0;
          end else if (!is_seeded_r) begin
            // First present sample seeds filters, shown percent and anchor.
            is_present_r     <= 1'b1;
            is_seeded_r      <= 1'b1;
            smooth_voltage_r <= SV_W'({req_r.raw_voltage_mv, {FRAC_BITS{1'b0}}});
            smooth_percent_r <= SP_W'({req_r.raw_percent, {FRAC_BITS{1'b0}}});
            shown_percent_r  <= req_r.raw_percent;
            anchor_percent_r <= req_r.raw_percent;
            anchor_time_r    <= req_r.now_ms;
          end else begin
            is_present_r     <= 1'b1;
            smooth_voltage_r <= sv_smooth;
            smooth_percent_r <= sp_smooth;
          end
        end
        S_SHOW: begin
          if (show_take) shown_percent_r <= filt;
        end
        S_ANCH: begin
          if (anchor_rise) begin
            anchor_percent_r <= shown_percent_r;
            anchor_time_r    <= req_r.now_ms;
            estimate_ready_r <= 1'b0;
          end else begin
            est_go_r <= est_cond;
          end
        end
        S_PROT: begin
          critical_run_r <= run_nxt;
        end
        S_DIVW: begin
          if (div_done) begin
            estimate_minutes_r <= est_sat;
            estimate_ready_r   <= 1'b1;
          end
        end
        S_IDLE, S_MULW, S_DONE: begin
        end
      endcase
    end
  end

  // Request capture and per-sample payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= {in_data.now_ms, in_data.battery_present, in_data.raw_voltage_mv, pct_capped,
                in_data.force_display, in_data.playing};
    end
    if (state_r == S_ANCH) begin
      den_r <= den_nxt;
    end
    if (state_r == S_PROT) begin
      act_r <= act_nxt;
      ivl_r <= ivl_nxt;
    end
  end

  // Output register: loaded once the slot is free, held while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_r.displayed_percent <= shown_percent_r;
      out_r.runtime_minutes   <= estimate_minutes_r;
      out_r.runtime_valid     <= estimate_ready_r;
      out_r.protect_action    <= act_r;
      out_r.next_interval_ms  <= ivl_r;
      out_r.seeded            <= is_seeded_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A valid estimate is only ever reported by a seeded monitor.
  a_est_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.runtime_valid || out_r.seeded))
    else $error("runtime estimate reported before seeding");

  // The shown percent never exceeds full charge.
  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.displayed_percent <= blm_pkg::PCT_MAX))
    else $error("displayed percent above 100");

  // Only the three defined actions appear.
  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.protect_action == blm_pkg::ACT_NONE ||
                     out_r.protect_action == blm_pkg::ACT_WARN ||
                     out_r.protect_action == blm_pkg::ACT_SHUT))
    else $error("undefined protection action");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  // The interval is always one of the three schedule values.
  a_ivl_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.next_interval_ms == blm_pkg::IVL_LOW ||
                     out_r.next_interval_ms == blm_pkg::IVL_PLAY ||
                     out_r.next_interval_ms == blm_pkg::IVL_IDLE))
    else $error("undefined sample interval");

endmodule

// ===== hdl/blm_mul.sv =====
// Shift-and-add multiplier: one bit of the short operand per cycle.
module blm_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [blm_pkg::MUL_A_W-1:0]   mcand,
  input  logic [blm_pkg::MUL_B_W-1:0]   mplier,
  output logic [blm_pkg::PROD_W-1:0]    prod,
  output logic                          done
);

  localparam int unsigned CNT_W = $clog2(blm_pkg::MUL_B_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(blm_pkg::MUL_B_W - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [blm_pkg::PROD_W-1:0]    acc_r;
  logic [blm_pkg::PROD_W-1:0]    mcand_r;
  logic [blm_pkg::MUL_B_W-1:0]   mplier_r;

  // Control: count the multiplier bits and flag the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand where the multiplier bit is set.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= blm_pkg::PROD_W'(mcand);
      mplier_r <= mplier;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[blm_pkg::PROD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[blm_pkg::MUL_B_W-1:1]};
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// ===== hdl/blm_div.sv =====
// Restoring divider: one quotient bit per cycle, dividend shifts out as quotient shifts in.
module blm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [blm_pkg::NUM_W-1:0]   dividend,
  input  logic [blm_pkg::DVS_W-1:0]   divisor,
  output logic [blm_pkg::NUM_W-1:0]   quotient,
  output logic                        done
);

  localparam int unsigned NUM_W = blm_pkg::NUM_W;
  localparam int unsigned DVS_W = blm_pkg::DVS_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W:0]     rem_sh;
  logic               fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  // Control: one step per quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder stays below the divisor, so it fits its own width.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DVS_W'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_r <= rem_sh[DVS_W-1:0];
      end
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== tb/sv/tb_battery_level_monitor.sv =====
module tb_battery_level_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  // Tracks the monitor's filters, anchor and critical counter, and holds the reports that
  // each accepted request should produce, oldest first.
  class battery_checker;
    logic [VOLT_BITS-1:0] warn_mv, crit_mv;
    logic [PCT_W-1:0]     warn_pct, crit_pct, hyst, min_drop;
    logic [TIME_W-1:0]    min_elapsed;
    logic [RUN_CNT_W-1:0] crit_needed;

    bit                   present_q, seeded_q, ready_q;
    logic [SV_W-1:0]      volt_q;
    logic [SP_W-1:0]      pct_q;
    logic [PCT_W-1:0]     shown_q, anchor_pct_q;
    logic [TIME_W-1:0]    anchor_time_q;
    logic [RUN_W-1:0]     minutes_q;
    logic [RUN_CNT_W-1:0] crit_run_q;

    out_item_t            pending_reports[$];
    int unsigned          fails;

    function new();
      warn_mv       = RST_LOW_WARN_MV;
      crit_mv       = RST_CRITICAL_MV;
      warn_pct      = RST_LOW_WARN_PCT;
      crit_pct      = RST_CRITICAL_PCT;
      hyst          = RST_DISPLAY_HYST;
      min_drop      = RST_RUNTIME_MIN_DROP;
      min_elapsed   = RST_RUNTIME_MIN_MS;
      crit_needed   = RST_CRIT_SAMPLES;
      present_q     = 1'b0;
      seeded_q      = 1'b0;
      ready_q       = 1'b0;
      volt_q        = '0;
      pct_q         = '0;
      shown_q       = '0;
      anchor_pct_q  = '0;
      anchor_time_q = '0;
      minutes_q     = '0;
      crit_run_q    = '0;
      fails         = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOW_WARN_MV:      warn_mv     = val[VOLT_BITS-1:0];
        CFG_CRITICAL_MV:      crit_mv     = val[VOLT_BITS-1:0];
        CFG_LOW_WARN_PCT:     warn_pct    = val[PCT_W-1:0];
        CFG_CRITICAL_PCT:     crit_pct    = val[PCT_W-1:0];
        CFG_DISPLAY_HYST:     hyst        = val[PCT_W-1:0];
        CFG_RUNTIME_MIN_DROP: min_drop    = val[PCT_W-1:0];
        CFG_RUNTIME_MIN_MS:   min_elapsed = val[TIME_W-1:0];
        CFG_CRIT_SAMPLES:     crit_needed = val[RUN_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // One smoothing step in Q8 weights, rounded half up.
    function logic [SV_W-1:0] ema(logic [SV_W-1:0] prev, logic [VOLT_BITS-1:0] raw);
      longint unsigned acc;
      acc = longint'(prev) * 184 + (longint'(raw) << FRAC_BITS) * 72 + 128;
      return SV_W'(acc >> 8);
    endfunction

    function bit volt_at_or_below(logic [VOLT_BITS-1:0] mv);
      return longint'(volt_q) <= (longint'(mv) << FRAC_BITS);
    endfunction

    function void take_sample(in_item_t s);
      logic [PCT_W-1:0]  pct;
      logic [TIME_W-1:0] elapsed;
      int unsigned       filt, diff, drop, need;
      longint unsigned   num, den, q;
      bit                crit, low;
      logic [1:0]        act;
      out_item_t         r;

      pct = (s.raw_percent > PCT_MAX) ? PCT_MAX : s.raw_percent;

      // Filter and display update.
      if (!s.battery_present) begin
        present_q  = 1'b0;
        crit_run_q = '0;
      end else if (!seeded_q) begin
        present_q     = 1'b1;
        volt_q        = SV_W'(s.raw_voltage_mv) << FRAC_BITS;
        pct_q         = SP_W'(pct) << FRAC_BITS;
        shown_q       = pct;
        anchor_pct_q  = pct;
        anchor_time_q = s.now_ms;
        seeded_q      = 1'b1;
      end else begin
        present_q = 1'b1;
        volt_q    = ema(volt_q, s.raw_voltage_mv);
        pct_q     = SP_W'(ema(SV_W'(pct_q), VOLT_BITS'(pct)));
        filt = (int'(pct_q) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (filt > PCT_MAX) filt = PCT_MAX;
        diff = (filt >= shown_q) ? filt - shown_q : shown_q - filt;
        if (s.force_display || diff >= hyst || filt <= SHOW_LOW_EDGE ||
            filt >= SHOW_HIGH_EDGE) shown_q = PCT_W'(filt);

        // A rising shown percent restarts the runtime anchor.
        if (shown_q > anchor_pct_q) begin
          anchor_pct_q  = shown_q;
          anchor_time_q = s.now_ms;
          ready_q       = 1'b0;
        end else begin
          drop    = anchor_pct_q - shown_q;
          elapsed = s.now_ms - anchor_time_q;
          need    = (min_drop == 0) ? 1 : min_drop;
          if (drop >= need && elapsed >= min_elapsed) begin
            num = 64'(shown_q);
            num = num * elapsed;
            den = 64'(drop) * 60000;
            q   = (2 * num + den) / (2 * den);
            minutes_q = (q > RUN_MAX) ? RUN_MAX : RUN_W'(q);
            ready_q   = 1'b1;
          end
        end
      end

      // Protection check.
      low = present_q && seeded_q &&
            (volt_at_or_below(warn_mv) || shown_q <= warn_pct);
      if (!present_q || !seeded_q) begin
        crit_run_q = '0;
        act = ACT_NONE;
      end else begin
        crit = volt_at_or_below(crit_mv) || shown_q <= crit_pct;
        if (!crit) crit_run_q = '0;
        else if (crit_run_q != CRIT_RUN_MAX) crit_run_q = crit_run_q + 1'b1;
        if (crit_run_q >= crit_needed) act = ACT_SHUT;
        else act = low ? ACT_WARN : ACT_NONE;
      end

      r.displayed_percent = shown_q;
      r.runtime_minutes   = minutes_q;
      r.runtime_valid     = ready_q;
      r.protect_action    = act;
      r.next_interval_ms  = low ? IVL_LOW : (s.playing ? IVL_PLAY : IVL_IDLE);
      r.seeded            = seeded_q;
      pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no request outstanding, got %p", $time, got);
        fails++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("displayed_percent", want.displayed_percent, got.displayed_percent);
      compare_field("runtime_minutes", want.runtime_minutes, got.runtime_minutes);
      compare_field("runtime_valid", want.runtime_valid, got.runtime_valid);
      compare_field("protect_action", want.protect_action, got.protect_action);
      compare_field("next_interval_ms", want.next_interval_ms, got.next_interval_ms);
      compare_field("seeded", want.seeded, got.seeded);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  battery_checker        chk = new();
  bit                    quiet = 1'b0;
  bit                    allow_absent = 1'b1;
  logic [TIME_W-1:0]     clock_ms;
  int                    level;

  battery_level_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random about a fifth of the time, except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  // Every report taken off the output is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_report(out_data);
  end

  // Generous overall limit.
  initial begin
    #15_000_000;
    $display("battery_level_monitor regression: fail");
    $finish;
  end

  function automatic in_item_t sample(logic [TIME_W-1:0] t, logic p, logic [VOLT_BITS-1:0] mv,
                                      logic [PCT_W-1:0] pc, logic f, logic pl);
    in_item_t s;
    s.now_ms          = t;
    s.battery_present = p;
    s.raw_voltage_mv  = mv;
    s.raw_percent     = pc;
    s.force_display   = f;
    s.playing         = pl;
    return s;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and holds it until taken.
  task automatic send_item(in_item_t s);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    chk.take_sample(s);
  endtask

  // Stops sending and waits for every outstanding report.
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    chk.write_reg(idx, val);
  endtask

  task automatic apply_config(logic [VOLT_BITS-1:0] wmv, logic [VOLT_BITS-1:0] cmv,
                              logic [PCT_W-1:0] wp, logic [PCT_W-1:0] cp,
                              logic [PCT_W-1:0] hy, logic [PCT_W-1:0] md,
                              logic [TIME_W-1:0] me, logic [RUN_CNT_W-1:0] cn);
    write_reg(CFG_LOW_WARN_MV, CFG_DATA_W'(wmv));
    write_reg(CFG_CRITICAL_MV, CFG_DATA_W'(cmv));
    write_reg(CFG_LOW_WARN_PCT, CFG_DATA_W'(wp));
    write_reg(CFG_CRITICAL_PCT, CFG_DATA_W'(cp));
    write_reg(CFG_DISPLAY_HYST, CFG_DATA_W'(hy));
    write_reg(CFG_RUNTIME_MIN_DROP, CFG_DATA_W'(md));
    write_reg(CFG_RUNTIME_MIN_MS, CFG_DATA_W'(me));
    write_reg(CFG_CRIT_SAMPLES, CFG_DATA_W'(cn));
    cfg_we <= 1'b0;
  endtask

  // Mostly a battery discharging with noise, with charging spells, removals and
  // the odd completely random sample that breaks the time sequence.
  task automatic next_sample(output in_item_t s);
    int unsigned pick;
    int          mv, pc;
    pick = $urandom_range(0, 99);
    s = '0;
    if (pick >= 90) begin
      s.now_ms          = $urandom;
      s.battery_present = allow_absent ? 1'($urandom_range(0, 1)) : 1'b1;
      s.raw_voltage_mv  = VOLT_BITS'($urandom_range(0, 8191));
      s.raw_percent     = PCT_W'($urandom_range(0, 127));
      s.force_display   = 1'($urandom_range(0, 1));
      s.playing         = 1'($urandom_range(0, 1));
    end else begin
      clock_ms = clock_ms + $urandom_range(1000, 900000);
      if (pick < 72) begin
        level = level - int'($urandom_range(0, 2));
        if (level < 0) level = ($urandom_range(0, 3) == 0) ? 100 : 0;
      end else if (pick < 80) begin
        level = level + int'($urandom_range(1, 10));
        if (level > 100) level = 100;
      end
      mv = 3000 + level * 12 + int'($urandom_range(0, 200)) - 100;
      pc = level + int'($urandom_range(0, 4)) - 2;
      if (pc < 0) pc = 0;
      if (pc > 100) pc = 100;
      if (level == 100 && $urandom_range(0, 3) == 0) pc = int'($urandom_range(101, 127));
      s.now_ms          = clock_ms;
      s.battery_present = !(pick >= 80 && allow_absent);
      s.raw_voltage_mv  = VOLT_BITS'(mv);
      s.raw_percent     = PCT_W'(pc);
      s.force_display   = ($urandom_range(0, 9) == 0);
      s.playing         = 1'($urandom_range(0, 1));
    end
  endtask

  task automatic run_random(int n);
    in_item_t s;
    repeat (n) begin
      next_sample(s);
      send_item(s);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under reset settings: a sample before any battery, the seeding
    // sample with an over-range percent, a discharge whose clock wraps past zero,
    // zero readings into shutdown, a removal, and a recharge.
    send_item(sample(32'd0, 1'b0, 13'd8191, 7'd127, 1'b1, 1'b1));
    send_item(sample(32'd0, 1'b1, 13'd4200, 7'd127, 1'b0, 1'b0));
    for (int k = 0; k < 15; k++) begin
      t = 32'hFFF0_0000 + 32'(k) * 32'd400000;
      send_item(sample(t, 1'b1, 13'(4200 - k * 70), 7'(100 - k * 7), 1'(k == 5), 1'(k % 2)));
    end
    send_item(sample(t + 32'd60000, 1'b1, 13'd0, 7'd0, 1'b0, 1'b1));
    send_item(sample(t + 32'd120000, 1'b1, 13'd0, 7'd0, 1'b0, 1'b0));
    send_item(sample(t + 32'd180000, 1'b0, 13'd0, 7'd0, 1'b0, 1'b0));
    send_item(sample(t + 32'd240000, 1'b1, 13'd8191, 7'd100, 1'b0, 1'b0));
    send_item(sample(32'hFFFF_FFFF, 1'b1, 13'd8191, 7'd127, 1'b1, 1'b1));
    clock_ms = 32'd1000;
    level    = 100;
    run_random(230);

    // Top of every range: every sample critical, so the counter saturates.
    drain();
    apply_config(13'd8191, 13'd8191, 7'd100, 7'd100, 7'd100, 7'd100, 32'hFFFF_FFFF, 8'd255);
    allow_absent = 1'b0;
    run_random(300);

    // All zero: a minimum drop of one percent, no minimum elapsed time, shutdown on every present sample.
    // This stretch also runs with no idling on either side.
    drain();
    allow_absent = 1'b1;
    apply_config(13'd0, 13'd0, 7'd0, 7'd0, 7'd0, 7'd0, 32'd0, 8'd0);
    quiet = 1'b1;
    level = 100;
    run_random(200);
    quiet = 1'b0;

    // Settings drawn at random around realistic battery thresholds.
    repeat (4) begin
      drain();
      apply_config(13'($urandom_range(3000, 4200)), 13'($urandom_range(2800, 3600)),
                   7'($urandom_range(0, 30)), 7'($urandom_range(0, 15)),
                   7'($urandom_range(0, 10)), 7'($urandom_range(1, 10)),
                   32'($urandom_range(0, 2000000)), 8'($urandom_range(1, 6)));
      level = int'($urandom_range(40, 100));
      run_random(170);
    end

    drain();
    repeat (64) @(posedge clk);
    if (chk.fails == 0 && chk.pending_reports.size() == 0) begin
      $display("battery_level_monitor regression: pass");
    end else begin
      $display("battery_level_monitor regression: fail");
    end
    $finish;
  end

endmodule
